// ===== rtl/vr_pkg.sv =====
package vr_pkg;

	localparam int VEC_W   = 21;
	localparam int ETA_W   = 20;
	// cosine range over the fraction-bit range; the clamp bounds it from above
	localparam int C_W     = 36;
	localparam int INNER_W = 32;
	localparam int SQ_W    = 64;
	localparam int ROOT_W  = SQ_W / 2;
	localparam int LANES   = 3;

	typedef logic signed [VEC_W-1:0]   vec_t;
	typedef logic [ETA_W-1:0]          eta_t;
	typedef logic signed [C_W-1:0]     cos_t;
	typedef logic signed [INNER_W-1:0] inner_t;

	// one classified transaction, front to back
	typedef struct packed {
		vec_t [LANES-1:0] d;
		vec_t [LANES-1:0] n;
		eta_t             eta;
		cos_t             c;
	} item_t;

	function automatic inner_t sat_inner(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (v > hi) begin
			sat_inner = inner_t'(hi);
		end else if (v < lo) begin
			sat_inner = inner_t'(lo);
		end else begin
			sat_inner = inner_t'(v);
		end
	endfunction

endpackage

// ===== rtl/vr_if.sv =====
interface vr_req_if;
	logic          valid;
	logic          ready;
	vr_pkg::vec_t  dir_x;
	vr_pkg::vec_t  dir_y;
	vr_pkg::vec_t  dir_z;
	vr_pkg::vec_t  norm_x;
	vr_pkg::vec_t  norm_y;
	vr_pkg::vec_t  norm_z;
	vr_pkg::eta_t  eta_ratio;

	modport source (output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
		input ready);
	modport sink (input valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
		output ready);
endinterface

interface vr_rsp_if;
	logic          valid;
	logic          ready;
	vr_pkg::vec_t  out_x;
	vr_pkg::vec_t  out_y;
	vr_pkg::vec_t  out_z;
	logic          clipped;

	modport source (output valid, out_x, out_y, out_z, clipped, input ready);
	modport sink (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

// ===== rtl/vr_front.sv =====
module vr_front #(
	parameter int FB    = 16,
	parameter int DEPTH = 4,
	parameter int CNT_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	vr_req_if.sink            req,
	input  logic [CNT_W-1:0]  fifo_cnt,
	output logic              push,
	output vr_pkg::item_t     push_item
);

	localparam int PROD_W = 2 * vr_pkg::VEC_W;
	localparam int DOT_W  = PROD_W + 2;
	localparam int NEG_W  = DOT_W + 1;
	localparam logic signed [NEG_W-1:0] ONE = NEG_W'(1) << FB;

	logic                             v_s1, v_s2;
	vr_pkg::vec_t [vr_pkg::LANES-1:0] d_s1, n_s1, d_s2, n_s2;
	vr_pkg::eta_t                     eta_s1, eta_s2;
	logic signed [PROD_W-1:0]         prod_s1 [vr_pkg::LANES];
	vr_pkg::cos_t                     c_s2;
	logic signed [DOT_W-1:0]          dot;
	logic signed [NEG_W-1:0]          negdot, cf;
	logic                             accept;
	logic [CNT_W:0]                   inflight;

	// room check counts transactions already in the two front stages
	assign inflight  = {1'b0, fifo_cnt} + (CNT_W+1)'(v_s1) + (CNT_W+1)'(v_s2);
	assign req.ready = inflight < (CNT_W+1)'(DEPTH);
	assign accept    = req.valid & req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_s1       <= {req.dir_z, req.dir_y, req.dir_x};
			n_s1       <= {req.norm_z, req.norm_y, req.norm_x};
			eta_s1     <= req.eta_ratio;
			prod_s1[0] <= $signed(req.dir_x) * $signed(req.norm_x);
			prod_s1[1] <= $signed(req.dir_y) * $signed(req.norm_y);
			prod_s1[2] <= $signed(req.dir_z) * $signed(req.norm_z);
		end
	end

	always_comb begin
		dot    = DOT_W'(prod_s1[0]) + DOT_W'(prod_s1[1]) + DOT_W'(prod_s1[2]);
		negdot = -(NEG_W'(dot));
		cf     = negdot >>> FB;
		if (cf > ONE) begin
			cf = ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			d_s2   <= d_s1;
			n_s2   <= n_s1;
			eta_s2 <= eta_s1;
			c_s2   <= vr_pkg::cos_t'(cf);
		end
	end

	assign push          = v_s2;
	assign push_item.d   = d_s2;
	assign push_item.n   = n_s2;
	assign push_item.eta = eta_s2;
	assign push_item.c   = c_s2;

endmodule

// ===== rtl/vr_fifo.sv =====
module vr_fifo #(
	parameter int DEPTH = 4,
	parameter int CNT_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vr_pkg::item_t    push_item,
	input  logic             pop,
	output vr_pkg::item_t    head,
	output logic             empty,
	output logic [CNT_W-1:0] cnt
);

	localparam int PTR_W = $clog2(DEPTH);

	vr_pkg::item_t    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign empty  = cnt_q == '0;
	assign do_pop = pop & ~empty;
	assign head   = slot_q[rd_q];
	assign cnt    = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/vr_sqrt.sv =====
module vr_sqrt #(
	parameter int SIDE_W = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_v,
	input  logic [vr_pkg::SQ_W-1:0]      in_x,
	input  logic [SIDE_W-1:0]            in_side,
	output logic                         out_v,
	output logic [vr_pkg::ROOT_W-1:0]    out_q,
	output logic [SIDE_W-1:0]            out_side
);

	localparam int N = vr_pkg::ROOT_W;

	// one result bit per stage, digit by digit from the top
	logic                    v_s    [N+1];
	logic [vr_pkg::SQ_W-1:0] rem_s  [N+1];
	logic [vr_pkg::SQ_W-1:0] root_s [N+1];
	logic [SIDE_W-1:0]       side_s [N+1];

	assign v_s[0]    = in_v;
	assign rem_s[0]  = in_x;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [vr_pkg::SQ_W-1:0] BIT = vr_pkg::SQ_W'(1) << (2 * (N - 1 - k));
		logic [vr_pkg::SQ_W-1:0] trial;
		logic                    take;

		assign trial = root_s[k] + BIT;
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? rem_s[k] - trial : rem_s[k];
				root_s[k+1] <= take ? (root_s[k] >> 1) + BIT : root_s[k] >> 1;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_v    = v_s[N];
	assign out_q    = root_s[N][N-1:0];
	assign out_side = side_s[N];

endmodule

// ===== rtl/vr_back.sv =====
module vr_back #(
	parameter int FB = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  vr_pkg::item_t  head,
	input  logic           empty,
	output logic           pop,
	vr_rsp_if.source       rsp
);

	localparam int L      = vr_pkg::LANES;
	localparam int CN_W   = vr_pkg::C_W + vr_pkg::VEC_W;
	localparam int T_W    = CN_W + 1;
	localparam int ET_W   = vr_pkg::ETA_W + 1 + vr_pkg::INNER_W;
	localparam int QN_W   = vr_pkg::ROOT_W + 1 + vr_pkg::VEC_W;
	localparam int R_W    = QN_W + 2;
	localparam int SIDE_W = L * (vr_pkg::INNER_W + vr_pkg::VEC_W);
	localparam logic signed [R_W-1:0] OUT_MAX = R_W'(1048575);
	localparam logic signed [R_W-1:0] OUT_MIN = -R_W'(1048576);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	vr_pkg::vec_t [L-1:0]       d_s1, n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8;
	vr_pkg::eta_t               eta_s1, eta_s2;
	logic signed [CN_W-1:0]     cn_s1 [L];
	vr_pkg::inner_t             t_s2  [L];
	logic signed [ET_W-1:0]     et_s3 [L];
	vr_pkg::inner_t             p_s4  [L];
	vr_pkg::inner_t [L-1:0]     p_s5, p_s6, p_s7, p_s8;
	logic [vr_pkg::SQ_W-1:0]    pp_s5 [L];
	logic [vr_pkg::SQ_W-1:0]    len2_s6, diff_s7;
	logic signed [QN_W-1:0]     qn_s8 [L];
	vr_pkg::vec_t               r_s9  [L];
	logic                       clip_s9;

	logic                       sq_v;
	logic [vr_pkg::ROOT_W-1:0]  sq_q;
	logic [SIDE_W-1:0]          sq_side;
	vr_pkg::inner_t [L-1:0]     sq_p;
	vr_pkg::vec_t [L-1:0]       sq_n;
	logic [vr_pkg::SQ_W-1:0]    one2;

	// the whole back pipeline moves when the output register can take a transaction
	assign adv  = ~v_s9 | rsp.ready;
	assign pop  = adv & ~empty;
	assign one2 = vr_pkg::SQ_W'(1) << (2 * FB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= sq_v;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [T_W-1:0]   tf;
		logic signed [QN_W:0]    nqn;
		logic signed [R_W-1:0]   rs;
		logic                    clip;
		if (adv) begin
			clip = 1'b0;
			d_s1   <= head.d;
			n_s1   <= head.n;
			eta_s1 <= head.eta;
			n_s2   <= n_s1;
			eta_s2 <= eta_s1;
			n_s3   <= n_s2;
			n_s4   <= n_s3;
			n_s5   <= n_s4;
			n_s6   <= n_s5;
			n_s7   <= n_s6;
			n_s8   <= sq_n;
			p_s6   <= p_s5;
			p_s7   <= p_s6;
			p_s8   <= sq_p;
			len2_s6 <= pp_s5[0] + pp_s5[1] + pp_s5[2];
			diff_s7 <= (len2_s6 >= one2) ? len2_s6 - one2 : one2 - len2_s6;
			for (int i = 0; i < L; i++) begin
				cn_s1[i] <= $signed(head.c) * $signed(head.n[i]);
				tf = T_W'($signed(d_s1[i])) + T_W'(cn_s1[i] >>> FB);
				t_s2[i]  <= vr_pkg::sat_inner(64'(tf));
				et_s3[i] <= $signed({1'b0, eta_s2}) * t_s2[i];
				p_s4[i]  <= vr_pkg::sat_inner(64'(et_s3[i] >>> FB));
				p_s5[i]  <= p_s4[i];
				// square taken at full width, the product needs up to 63 bits
				pp_s5[i] <= vr_pkg::SQ_W'(64'(p_s4[i]) * 64'(p_s4[i]));
				qn_s8[i] <= $signed({1'b0, sq_q}) * $signed(sq_n[i]);
				nqn = -((QN_W+1)'(qn_s8[i]));
				rs  = R_W'($signed(p_s8[i])) + R_W'(nqn >>> FB);
				if (rs > OUT_MAX) begin
					r_s9[i] <= vr_pkg::vec_t'(OUT_MAX);
					clip = 1'b1;
				end else if (rs < OUT_MIN) begin
					r_s9[i] <= vr_pkg::vec_t'(OUT_MIN);
					clip = 1'b1;
				end else begin
					r_s9[i] <= vr_pkg::vec_t'(rs);
				end
			end
			clip_s9 <= clip;
		end
	end

	vr_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (v_s7),
		.in_x     (diff_s7),
		.in_side  ({p_s7, n_s7}),
		.out_v    (sq_v),
		.out_q    (sq_q),
		.out_side (sq_side)
	);

	assign {sq_p, sq_n} = sq_side;

	assign rsp.valid   = v_s9;
	assign rsp.out_x   = r_s9[0];
	assign rsp.out_y   = r_s9[1];
	assign rsp.out_z   = r_s9[2];
	assign rsp.clipped = clip_s9;

endmodule

// ===== rtl/vector_refraction.sv =====
// Vector refraction by Snell's law. Each req transaction carries an incoming
// direction, a surface normal and an index ratio in fixed point with
// FRACTION_BITS fraction bits; each rsp transaction returns the refracted
// direction, saturated to 21 bits, with clipped set if any component hit a
// rail. One transaction per cycle is accepted and delivered in steady state
// while rsp keeps taking transactions. The path from req to rsp runs through
// 2 front stages, at least one in the queue, 8 back stages, 32 square-root
// stages and the output register. The square root takes one result bit per
// stage and makes up most of that depth. There is no per-transaction state,
// so transactions are independent and stream freely.
module vector_refraction #(
	parameter int FRACTION_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	vr_req_if.sink    req,
	vr_rsp_if.source  rsp
);

	localparam int DEPTH = 4;
	localparam int CNT_W = $clog2(DEPTH) + 1;

	// front: dot product and clamped cosine
	logic                 push;
	vr_pkg::item_t        push_item;
	// queue between front and back
	vr_pkg::item_t        head;
	logic                 empty;
	logic                 pop;
	logic [CNT_W-1:0]     fifo_cnt;

	vr_front #(.FB(FRACTION_BITS), .DEPTH(DEPTH), .CNT_W(CNT_W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.fifo_cnt  (fifo_cnt),
		.push      (push),
		.push_item (push_item)
	);

	vr_fifo #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.cnt       (fifo_cnt)
	);

	// back: perpendicular part, length, square root, parallel part, saturation
	vr_back #(.FB(FRACTION_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/vr_check.sv =====
module vr_check (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input vr_pkg::vec_t  out_x,
	input vr_pkg::vec_t  out_y,
	input vr_pkg::vec_t  out_z,
	input logic          clipped
);

	localparam vr_pkg::vec_t VMAX = 21'sd1048575;
	localparam vr_pkg::vec_t VMIN = -21'sd1048576;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(clipped))
		else $error("rsp transaction changed while stalled");

	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && clipped |-> out_x == VMAX || out_x == VMIN || out_y == VMAX
			|| out_y == VMIN || out_z == VMAX || out_z == VMIN)
		else $error("clipped without a component at a rail");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid)
		else $error("rsp valid right after reset");

endmodule

bind vector_refraction vr_check u_vr_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.out_x     (rsp.out_x),
	.out_y     (rsp.out_y),
	.out_z     (rsp.out_z),
	.clipped   (rsp.clipped)
);
